>>> sv/edfts_pkg.sv
package edfts_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CNT_CFG_W = 4;

	// Input transaction: tuser carries the mode, tdata the task fields.
	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned S_TUSER_W = 1;
	localparam int unsigned M_TDATA_W = 40;
	localparam int unsigned M_TUSER_W = 1;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// One task table entry, kept as a single memory word.
	typedef struct packed {
		logic [FIELD_W-1:0] phase;
		logic [TIME_W-1:0]  abs_dl;
		logic [FIELD_W-1:0] rem;
		logic [FIELD_W-1:0] rel_dl;
		logic [FIELD_W-1:0] burst;
		logic [FIELD_W-1:0] period;
	} task_entry_t;

	// Running best candidate of the deadline scan.
	typedef struct packed {
		logic              found;
		logic [TIME_W-1:0] abs_dl;
	} best_ref_t;

	// Outcome of evaluating one entry during the scan.
	typedef struct packed {
		task_entry_t upd;
		logic        take;
	} eval_res_t;

endpackage

>>> sv/edfts_eval.sv
module edfts_eval (
	input  edfts_pkg::task_entry_t            entry,
	input  logic                              phase_ok,
	input  logic [edfts_pkg::TIME_W-1:0]      cur_time,
	input  edfts_pkg::best_ref_t              best,
	output edfts_pkg::eval_res_t              res
);
	import edfts_pkg::*;

	logic [FIELD_W-1:0] phase;
	logic               release_now;
	logic [FIELD_W:0]   phase_inc;

	// Entries whose phase was cleared by a load read as phase zero.
	assign phase = phase_ok ? entry.phase : '0;

	// A task is released when its period divides a nonzero time.
	assign release_now = (cur_time != '0) && (entry.period != '0) && (phase == '0);

	assign phase_inc = {1'b0, phase} + (FIELD_W+1)'(1);

	always_comb begin
		res.upd = entry;
		if (release_now) begin
			res.upd.rem    = entry.burst;
			res.upd.abs_dl = cur_time + TIME_W'(entry.rel_dl);
		end
		// Phase tracks time modulo the period.
		if (phase_inc >= {1'b0, entry.period}) begin
			res.upd.phase = '0;
		end else begin
			res.upd.phase = phase_inc[FIELD_W-1:0];
		end
		// Strictly earlier deadline wins, so the lowest index keeps ties.
		res.take = (res.upd.rem != '0) && (!best.found || (res.upd.abs_dl < best.abs_dl));
	end

endmodule

>>> sv/edf_tick_scheduler_core.sv
// Earliest-deadline-first tick scheduler over a table of up to NUM_TASKS periodic tasks.
// A load transaction (tuser = 0) writes one task entry, restarts time at zero and forgets
// the previous choice; it produces no result. A tick transaction
// (tuser = 1) releases due tasks, picks the ready task with the earliest absolute deadline
// (lowest index on ties), runs it one unit and emits one result transaction. The task table
// is a single-port-read memory that one shared evaluate-and-compare unit walks one entry per
// cycle. With n the task count saturated at NUM_TASKS, a tick holds the input while the unit
// reads the n entries, waits for the read data of the last entry, sees that the walk has ended
// and then writes back the chosen task and hands the result to the output register. With no
// task taking part the walk reads no entry. The write-back step waits for as long as an
// earlier result is still held by the receiver. The output register lets the next transaction
// enter while a result is waiting.
module edf_tick_scheduler_core #(
	parameter int NUM_TASKS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration: task_count.
	input  logic                               cfg_we,
	input  logic [edfts_pkg::CNT_CFG_W-1:0]    cfg_wdata,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata: task_index[2:0], task_period[18:3], task_burst[34:19],
	// task_deadline[50:35], zero fill[55:51].
	input  logic [edfts_pkg::S_TDATA_W-1:0]    s_tdata,
	// s_tuser: mode[0].
	input  logic [edfts_pkg::S_TUSER_W-1:0]    s_tuser,
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata: chosen_task[2:0], switched[3], tick_time[35:4], zero fill[39:36].
	output logic [edfts_pkg::M_TDATA_W-1:0]    m_tdata,
	// m_tuser: idle[0].
	output logic [edfts_pkg::M_TUSER_W-1:0]    m_tuser
);
	import edfts_pkg::*;

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W = $clog2(NUM_TASKS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	logic [CNT_CFG_W-1:0] task_count_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     rd_cnt_q;
	logic [CNT_W-1:0]     n_eff;

	task_entry_t          mem [NUM_TASKS];
	task_entry_t          rd_word_s1;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [NUM_TASKS-1:0] phase_ok_q;

	logic [TIME_W-1:0]    time_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_W-1:0]    best_dl_q;
	task_entry_t          best_word_q;

	logic                 last_valid_q;
	logic                 last_idle_q;
	logic [IDX_W-1:0]     last_idx_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic                 s_acc;
	logic                 load_acc;
	logic                 tick_acc;
	logic                 issue;
	logic                 out_free;
	logic                 finish_go;
	logic [7:0]           ld_ext;
	logic [IDX_W-1:0]     ld_idx;
	logic                 ld_in_range;
	logic [7:0]           best_ext;
	logic                 switched;
	best_ref_t            best_ref;
	eval_res_t            ev;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	task_entry_t          wdata;
	task_entry_t          load_word;
	task_entry_t          decr_word;

	// Handshake decode.
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign load_acc  = s_acc && (s_tuser[0] == MODE_LOAD);
	assign tick_acc  = s_acc && (s_tuser[0] == MODE_TICK);
	assign out_free  = !m_tvalid_q || m_tready;
	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign issue     = (state_q == ST_SCAN) && (rd_cnt_q < n_q);

	// Task count saturates at the table depth.
	always_comb begin
		if (int'(task_count_q) > NUM_TASKS) begin
			n_eff = CNT_W'(NUM_TASKS);
		end else begin
			n_eff = CNT_W'(task_count_q);
		end
	end

	// Load index, checked against the table depth.
	assign ld_ext      = 8'(s_tdata[2:0]);
	assign ld_idx      = ld_ext[IDX_W-1:0];
	assign ld_in_range = int'(s_tdata[2:0]) < NUM_TASKS;

	always_comb begin
		load_word        = '0;
		load_word.period = s_tdata[18:3];
		load_word.burst  = s_tdata[34:19];
		load_word.rel_dl = s_tdata[50:35];
		load_word.rem    = s_tdata[34:19];
		load_word.abs_dl = TIME_W'(s_tdata[50:35]);
		decr_word        = best_word_q;
		decr_word.rem    = best_word_q.rem - FIELD_W'(1);
	end

	// Shared evaluate-and-compare unit for the entry read in the previous cycle.
	assign best_ref.found  = found_q;
	assign best_ref.abs_dl = best_dl_q;

	edfts_eval u_eval (
		.entry    (rd_word_s1),
		.phase_ok (phase_ok_q[idx_s1]),
		.cur_time (time_q),
		.best     (best_ref),
		.res      (ev)
	);

	// Single write port: loads, scan write-back and the final decrement never overlap.
	always_comb begin
		we    = 1'b0;
		waddr = ld_idx;
		wdata = load_word;
		if (load_acc && ld_in_range) begin
			we = 1'b1;
		end else if (vld_s1) begin
			we    = 1'b1;
			waddr = idx_s1;
			wdata = ev.upd;
		end else if (finish_go && found_q) begin
			we    = 1'b1;
			waddr = best_idx_q;
			wdata = decr_word;
		end
	end

	// Task table memory with a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_word_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
	end

	// Sequencer, scan pipeline and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			task_count_q <= CNT_CFG_W'(1);
			n_q          <= '0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			phase_ok_q   <= '0;
			time_q       <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_dl_q    <= '0;
			best_word_q  <= '0;
			last_valid_q <= 1'b0;
			last_idle_q  <= 1'b0;
			last_idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				task_count_q <= cfg_wdata;
			end
			vld_s1 <= issue;
			if (issue) begin
				idx_s1   <= rd_cnt_q[IDX_W-1:0];
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (vld_s1) begin
				phase_ok_q[idx_s1] <= 1'b1;
				if (ev.take) begin
					found_q     <= 1'b1;
					best_idx_q  <= idx_s1;
					best_dl_q   <= ev.upd.abs_dl;
					best_word_q <= ev.upd;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						phase_ok_q   <= '0;
						time_q       <= '0;
						last_valid_q <= 1'b0;
					end else if (tick_acc) begin
						rd_cnt_q <= '0;
						n_q      <= n_eff;
						found_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!issue && !vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						last_valid_q <= 1'b1;
						last_idle_q  <= !found_q;
						last_idx_q   <= best_idx_q;
						time_q       <= time_q + TIME_W'(1);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields.
	assign best_ext = 8'(best_idx_q);
	assign switched = !last_valid_q || (found_q == last_idle_q) ||
		(found_q && (last_idx_q != best_idx_q));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			m_tdata_q <= {4'b0000, time_q, switched,
				(found_q ? best_ext[2:0] : 3'b000)};
			m_tuser_q <= M_TUSER_W'(!found_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> sv/edfts_checker.sv
module edfts_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [edfts_pkg::S_TUSER_W-1:0]    s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [edfts_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [edfts_pkg::M_TUSER_W-1:0]    m_tuser
);
	import edfts_pkg::*;

	// A tick transaction starts a scan, so the input side closes next cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == MODE_TICK) |=> !s_tready)
		else $error("input still ready after a tick transaction");

	// A load transaction leaves the input side ready in the next cycle.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == MODE_LOAD) |=> s_tready)
		else $error("input not ready after a load transaction");

	// An idle result reports task zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[2:0] == 3'b000))
		else $error("idle result with nonzero task");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind edf_tick_scheduler_core edfts_checker u_edfts_checker (.*);

>>> dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import edfts_pkg::*;

	localparam int NTASK = 8;
	localparam int ITEM_TARGET = 1550;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	// Choice markers besides a task index.
	localparam int PICK_NONE = -1;
	localparam int PICK_IDLE = -2;

	// One expected scheduling decision.
	typedef struct packed {
		logic [2:0]        chosen;
		logic              idle;
		logic              switched;
		logic [TIME_W-1:0] tick_time;
	} pick_t;

	// Tracks the task table, predicts each tick's decision and checks results.
	class tick_checker;
		logic [FIELD_W-1:0] period_of [NTASK];
		logic [FIELD_W-1:0] burst_of [NTASK];
		logic [FIELD_W-1:0] rel_dl_of [NTASK];
		logic [FIELD_W-1:0] work_left [NTASK];
		logic [TIME_W-1:0]  due_at [NTASK];
		logic [FIELD_W-1:0] phase [NTASK];
		logic [TIME_W-1:0]  now;
		int                 last_pick;
		logic [CNT_CFG_W-1:0] task_count;
		pick_t              expected_picks [$];
		int                 errors;

		function new();
			int i;
			for (i = 0; i < NTASK; i++) begin
				period_of[i] = '0;
				burst_of[i] = '0;
				rel_dl_of[i] = '0;
				work_left[i] = '0;
				due_at[i] = '0;
				phase[i] = '0;
			end
			now = '0;
			last_pick = PICK_NONE;
			task_count = 4'd1;
			errors = 0;
		endfunction

		function void set_task_count(logic [CNT_CFG_W-1:0] v);
			task_count = v;
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction

		function void flag(string what, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] got_v);
			errors++;
			if (errors <= 10)
				$display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what,
					exp_v, got_v);
		endfunction

		// Apply one accepted input transaction to the predicted state.
		function void note_input(logic [S_TUSER_W-1:0] user, logic [S_TDATA_W-1:0] data);
			int i;
			int n;
			int best;
			bit found;
			int choice;
			logic [FIELD_W:0] nxt;
			pick_t p;
			if (user[0] == MODE_LOAD) begin
				i = int'(data[2:0]);
				period_of[i] = data[18:3];
				burst_of[i] = data[34:19];
				rel_dl_of[i] = data[50:35];
				work_left[i] = data[34:19];
				due_at[i] = {16'd0, data[50:35]};
				for (i = 0; i < NTASK; i++)
					phase[i] = '0;
				now = '0;
				last_pick = PICK_NONE;
				return;
			end
			n = (int'(task_count) > NTASK) ? NTASK : int'(task_count);
			best = 0;
			found = 0;
			// Release due tasks and look for the earliest deadline.
			for (i = 0; i < n; i++) begin
				if (now != 0 && period_of[i] != 0 && phase[i] == 0) begin
					work_left[i] = burst_of[i];
					due_at[i] = now + {16'd0, rel_dl_of[i]};
				end
				if (work_left[i] != 0 && (!found || due_at[i] < due_at[best])) begin
					best = i;
					found = 1;
				end
			end
			choice = found ? best : PICK_IDLE;
			p.chosen = found ? best[2:0] : 3'd0;
			p.idle = !found;
			p.switched = (choice != last_pick);
			p.tick_time = now;
			expected_picks.push_back(p);
			last_pick = choice;
			if (found)
				work_left[best] = work_left[best] - FIELD_W'(1);
			// Phase tracks time modulo the period.
			for (i = 0; i < n; i++) begin
				nxt = {1'b0, phase[i]} + (FIELD_W+1)'(1);
				if (nxt >= {1'b0, period_of[i]})
					nxt = '0;
				phase[i] = nxt[FIELD_W-1:0];
			end
			now = now + TIME_W'(1);
		endfunction

		// Compare one accepted result transaction with the oldest expectation.
		function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
			pick_t p;
			if (expected_picks.size() == 0) begin
				flag("unexpected result, tdata", '0, data[TIME_W-1:0]);
				return;
			end
			p = expected_picks.pop_front();
			if (data[2:0] !== p.chosen)
				flag("chosen_task", TIME_W'(p.chosen), TIME_W'(data[2:0]));
			if (user[0] !== p.idle)
				flag("idle", TIME_W'(p.idle), TIME_W'(user[0]));
			if (data[3] !== p.switched)
				flag("switched", TIME_W'(p.switched), TIME_W'(data[3]));
			if (data[35:4] !== p.tick_time)
				flag("tick_time", p.tick_time, data[35:4]);
		endfunction

		function int close();
			while (expected_picks.size() != 0) begin
				flag("missing result, tick_time", expected_picks[0].tick_time, '0);
				void'(expected_picks.pop_front());
			end
			return errors;
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CNT_CFG_W-1:0]    cfg_wdata = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_W-1:0]    s_tdata = '0;
	logic [S_TUSER_W-1:0]    s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_W-1:0]    m_tdata;
	logic [M_TUSER_W-1:0]    m_tuser;

	tick_checker sb = new();
	int          items_sent = 0;
	bit          calm = 0;
	bit          hold_req = 0;
	int unsigned cycles = 0;

	edf_tick_scheduler_core #(.NUM_TASKS(NTASK)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** edf_tick_scheduler_core: FAILED **");
			$finish;
		end
	end

	// Both monitors sample pre-edge values right after the rising edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Result receiver: random stalls, one long hold-off to back the block up.
	initial begin
		bit held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 17);
		end
	end

	// Offer one input transaction and wait until it is taken.
	task automatic send_item(input logic mode, input logic [S_TDATA_W-1:0] data);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		calm = (items_sent >= 700 && items_sent < 950);
		if (items_sent >= 400)
			hold_req = 1;
	endtask

	task automatic send_load(input logic [2:0] idx, input logic [15:0] per,
			input logic [15:0] bur, input logic [15:0] dl);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[2:0] = idx;
		d[18:3] = per;
		d[34:19] = bur;
		d[50:35] = dl;
		send_item(MODE_LOAD, d);
	endtask

	// Task fields of a tick are don't-care, so they carry noise.
	task automatic send_tick();
		send_item(MODE_TICK, S_TDATA_W'({$urandom, $urandom}));
	endtask

	function automatic logic [15:0] rand_period();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 16'd0;
		if (r < 16)
			return 16'($urandom_range(65535, 0));
		if (r < 20)
			return 16'hffff;
		return 16'($urandom_range(12, 1));
	endfunction

	function automatic logic [15:0] rand_burst();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 16'd0;
		if (r < 18)
			return 16'($urandom_range(65535, 0));
		return 16'($urandom_range(6, 1));
	endfunction

	function automatic logic [15:0] rand_deadline();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 16'd0;
		if (r < 20)
			return 16'($urandom_range(65535, 0));
		return 16'($urandom_range(24, 0));
	endfunction

	// Mostly reload entries that take part in the current schedule.
	task automatic send_rand_load(input int span);
		logic [2:0] idx;
		if (span >= 1 && span <= NTASK && $urandom_range(99) < 80)
			idx = 3'($urandom_range(span - 1, 0));
		else
			idx = 3'($urandom_range(NTASK - 1, 0));
		send_load(idx, rand_period(), rand_burst(), rand_deadline());
	endtask

	// Let every result out, then give a trailing load time to settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_task_count(input logic [CNT_CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_task_count(v);
	endtask

	// Main sequence.
	initial begin
		int r;
		int cnt;
		int ticks;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table first so no tick ever reads an empty entry.
		send_load(3'd0, 16'd4, 16'd2, 16'd4);
		send_load(3'd1, 16'd0, 16'd3, 16'd10);
		send_load(3'd2, 16'hffff, 16'hffff, 16'hffff);
		send_load(3'd3, 16'd1, 16'd0, 16'd0);
		send_load(3'd4, 16'd3, 16'd1, 16'd0);
		send_load(3'd5, 16'd6, 16'd2, 16'd3);
		send_load(3'd6, 16'd2, 16'd1, 16'd3);
		send_load(3'd7, 16'd5, 16'd1, 16'd2);
		repeat (3) send_tick();

		// Full table, a reload in the middle of a run, then empty and oversized counts.
		wait_drained();
		write_task_count(4'd8);
		repeat (8) send_tick();
		send_load(3'd3, 16'd7, 16'd2, 16'd1);
		repeat (2) send_tick();
		wait_drained();
		write_task_count(4'd0);
		repeat (2) send_tick();
		wait_drained();
		write_task_count(4'd15);
		repeat (2) send_tick();

		// Random phases: a count setting, then reload-and-run sequences.
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			r = $urandom_range(99);
			if (r < 10)
				cnt = 0;
			else if (r < 20)
				cnt = $urandom_range(15, 9);
			else if (r < 35)
				cnt = NTASK;
			else
				cnt = $urandom_range(NTASK, 1);
			write_task_count(cnt[CNT_CFG_W-1:0]);
			repeat ($urandom_range(4, 1)) begin
				repeat ($urandom_range(3, 1)) send_rand_load(cnt);
				ticks = $urandom_range(60, 5);
				repeat (ticks) begin
					if ($urandom_range(99) < 5)
						send_rand_load(cnt);
					else
						send_tick();
				end
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.close() == 0)
			$display("** edf_tick_scheduler_core: PASSED **");
		else
			$display("** edf_tick_scheduler_core: FAILED **");
		$finish;
	end

endmodule
